/* design/lz77e_pkg.sv */
package lz77e_pkg;

   localparam int SYMBOL_W       = 8;
   localparam int FIELD_W        = 4;
   localparam int WINDOW_DEFAULT = 10;

endpackage

/* design/lz77e_if.sv */
interface lz77e_req_if
   import lz77e_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [SYMBOL_W-1:0] symbol;
   logic                stream_end;

   modport source (output valid, output symbol, output stream_end, input ready);
   modport sink   (input valid, input symbol, input stream_end, output ready);
endinterface

interface lz77e_rsp_if
   import lz77e_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [FIELD_W-1:0]  back_offset;
   logic [FIELD_W-1:0]  match_length;
   logic [SYMBOL_W-1:0] follow_byte;
   logic                run_last;
   logic                stream_done;

   modport source (output valid, output back_offset, output match_length,
                   output follow_byte, output run_last, output stream_done,
                   input ready);
   modport sink   (input valid, input back_offset, input match_length,
                   input follow_byte, input run_last, input stream_done,
                   output ready);
endinterface

/* design/lz77e_match.sv */
// Match length of the lookahead against the history from one start position.
module lz77e_match
   import lz77e_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic [SYMBOL_W-1:0]               hist [WINDOW],
   input  logic [SYMBOL_W-1:0]               la [WINDOW+1],
   input  logic [$clog2(WINDOW+1)-1:0]       pos,
   input  logic [$clog2(WINDOW+1)-1:0]       cap,
   output logic [$clog2(WINDOW+1)-1:0]       match_len
);
   localparam int HF_W  = $clog2(WINDOW + 1);
   localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   logic [HF_W:0] idx;
   logic          hit;
   logic          run;

   always_comb begin
      run       = 1'b1;
      match_len = '0;
      idx       = '0;
      hit       = 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
         idx = (HF_W+1)'(pos) + (HF_W+1)'(i);
         hit = (idx < (HF_W+1)'(WINDOW)) && (HF_W'(i) < cap)
               && (hist[idx[POS_W-1:0]] == la[i]);
         run = run & hit;
         match_len = match_len + HF_W'(run);
      end
   end
endmodule

/* design/lz77_sliding_window_encoder_top.sv */
// LZ77 encoder over a sliding history of WINDOW bytes.
// req_ch carries one byte per request with stream_end on the last byte of a
// stream; rsp_ch carries tokens (back_offset, match_length, follow_byte).
// A request may cause no token, or several; run_last marks the last token
// caused by a request, stream_done the final token of a stream, after which
// all history is dropped and the next byte opens a new stream.
// req_ch.ready is high only while the encoder is idle. Each request is
// accepted and then checked; each token then scans every filled history
// position (one candidate start compared per cycle by the match unit),
// resolves the best match, consumes its bytes and is emitted: with a full
// window a request that yields one literal scans all WINDOW positions, while
// a request that only joins the lookahead just passes accept and check.
// Tokens leave through an output register; a request is taken while a token
// still waits there, and a stalled receiver holds the sequencer in its emit
// step until the register frees.
// Synchronous reset empties history and lookahead and drops any pending
// token; no clearing pass is needed.
module lz77_sliding_window_encoder_top
   import lz77e_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input logic         clock,
   input logic         reset,
   lz77e_req_if.sink   req_ch,
   lz77e_rsp_if.source rsp_ch
);
   localparam int HF_W  = $clog2(WINDOW + 1);
   localparam int LA_W  = $clog2(WINDOW + 2);
   localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   typedef enum logic [2:0] {IDLE, CHECK, SCAN, RESOLVE, CONSUME, EMIT} state_type;

   state_type           state_ff, state_in;
   logic [SYMBOL_W-1:0] hist_ff [WINDOW];
   logic [SYMBOL_W-1:0] hist_in [WINDOW];
   logic [SYMBOL_W-1:0] la_ff [WINDOW+1];
   logic [SYMBOL_W-1:0] la_in [WINDOW+1];
   logic [HF_W-1:0]     hf_ff, hf_in;
   logic [LA_W-1:0]     la_fill_ff, la_fill_in;
   logic                end_ff, end_in;
   logic [HF_W-1:0]     pos_ff, pos_in;
   logic [HF_W-1:0]     best_len_ff, best_len_in;
   logic [HF_W-1:0]     best_pos_ff, best_pos_in;
   logic [HF_W-1:0]     tok_off_ff, tok_off_in;
   logic [HF_W-1:0]     tok_len_ff, tok_len_in;
   logic [SYMBOL_W-1:0] tok_follow_ff, tok_follow_in;
   logic [LA_W-1:0]     cnt_ff, cnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [FIELD_W-1:0]  rsp_off_ff, rsp_off_in;
   logic [FIELD_W-1:0]  rsp_len_ff, rsp_len_in;
   logic [SYMBOL_W-1:0] rsp_follow_ff, rsp_follow_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                rsp_done_ff, rsp_done_in;

   logic                more;
   logic [HF_W-1:0]     w2;
   logic [HF_W-1:0]     rem;
   logic [HF_W-1:0]     cap;
   logic [HF_W-1:0]     match_len;
   logic [HF_W+FIELD_W-1:0] off_ext;
   logic [HF_W+FIELD_W-1:0] len_ext;

   assign req_ch.ready        = (state_ff == IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.back_offset  = rsp_off_ff;
   assign rsp_ch.match_length = rsp_len_ff;
   assign rsp_ch.follow_byte  = rsp_follow_ff;
   assign rsp_ch.run_last     = rsp_last_ff;
   assign rsp_ch.stream_done  = rsp_done_ff;

   // another token is due with the current fills
   assign more = (la_fill_ff != '0)
                 && (end_ff || ((LA_W+1)'(la_fill_ff) >= (LA_W+1)'(hf_ff) + 1'b1));

   always_comb begin
      if ((LA_W+1)'(hf_ff) < (LA_W+1)'(la_fill_ff)) begin
         w2 = hf_ff;
      end else begin
         w2 = HF_W'(la_fill_ff);
      end
      rem = hf_ff - pos_ff;
      cap = (rem < w2) ? rem : w2;
   end

   lz77e_match #(
      .WINDOW (WINDOW)
   ) u_match (
      .hist      (hist_ff),
      .la        (la_ff),
      .pos       (pos_ff),
      .cap       (cap),
      .match_len (match_len)
   );

   always_comb begin
      state_in      = state_ff;
      hist_in       = hist_ff;
      la_in         = la_ff;
      hf_in         = hf_ff;
      la_fill_in    = la_fill_ff;
      end_in        = end_ff;
      pos_in        = pos_ff;
      best_len_in   = best_len_ff;
      best_pos_in   = best_pos_ff;
      tok_off_in    = tok_off_ff;
      tok_len_in    = tok_len_ff;
      tok_follow_in = tok_follow_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_follow_in = rsp_follow_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;
      off_ext       = (HF_W+FIELD_W)'(tok_off_ff);
      len_ext       = (HF_W+FIELD_W)'(tok_len_ff);

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         IDLE: begin
            if (req_ch.valid) begin
               if ((LA_W+1)'(la_fill_ff) < (LA_W+1)'(WINDOW + 1)) begin
                  la_in[la_fill_ff[HF_W-1:0]] = req_ch.symbol;
                  la_fill_in = la_fill_ff + 1'b1;
               end
               end_in   = req_ch.stream_end;
               state_in = CHECK;
            end
         end
         CHECK: begin
            pos_in      = '0;
            best_len_in = '0;
            best_pos_in = '0;
            if (more) begin
               state_in = SCAN;
            end else begin
               if (end_ff) begin
                  hf_in      = '0;
                  la_fill_in = '0;
                  end_in     = 1'b0;
               end
               state_in = IDLE;
            end
         end
         SCAN: begin
            if (pos_ff == hf_ff) begin
               state_in = RESOLVE;
            end else begin
               if (match_len > best_len_ff) begin
                  best_len_in = match_len;
                  best_pos_in = pos_ff;
               end
               pos_in = pos_ff + 1'b1;
            end
         end
         RESOLVE: begin
            if (best_len_ff != '0) begin
               tok_off_in = hf_ff - best_pos_ff;
               tok_len_in = best_len_ff;
               if ((LA_W+1)'(best_len_ff) < (LA_W+1)'(la_fill_ff)) begin
                  tok_follow_in = la_ff[best_len_ff];
                  cnt_in        = LA_W'(best_len_ff) + 1'b1;
               end else begin
                  tok_follow_in = '0;
                  cnt_in        = LA_W'(best_len_ff);
               end
            end else begin
               tok_off_in    = '0;
               tok_len_in    = '0;
               tok_follow_in = la_ff[0];
               cnt_in        = LA_W'(1);
            end
            state_in = CONSUME;
         end
         CONSUME: begin
            if (cnt_ff == '0) begin
               state_in = EMIT;
            end else begin
               if ((LA_W+1)'(hf_ff) < (LA_W+1)'(WINDOW)) begin
                  hist_in[hf_ff[POS_W-1:0]] = la_ff[0];
                  hf_in = hf_ff + 1'b1;
               end else begin
                  for (int i = 0; i < WINDOW - 1; i++) begin
                     hist_in[i] = hist_ff[i+1];
                  end
                  hist_in[WINDOW-1] = la_ff[0];
               end
               for (int i = 0; i < WINDOW; i++) begin
                  la_in[i] = la_ff[i+1];
               end
               la_fill_in = la_fill_ff - 1'b1;
               cnt_in     = cnt_ff - 1'b1;
            end
         end
         EMIT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_off_in    = off_ext[FIELD_W-1:0];
               rsp_len_in    = len_ext[FIELD_W-1:0];
               rsp_follow_in = tok_follow_ff;
               rsp_last_in   = !more;
               rsp_done_in   = end_ff && !more;
               pos_in        = '0;
               best_len_in   = '0;
               best_pos_in   = '0;
               if (more) begin
                  state_in = SCAN;
               end else begin
                  if (end_ff) begin
                     hf_in      = '0;
                     la_fill_in = '0;
                     end_in     = 1'b0;
                  end
                  state_in = IDLE;
               end
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      hist_ff       <= hist_in;
      la_ff         <= la_in;
      pos_ff        <= pos_in;
      best_len_ff   <= best_len_in;
      best_pos_ff   <= best_pos_in;
      tok_off_ff    <= tok_off_in;
      tok_len_ff    <= tok_len_in;
      tok_follow_ff <= tok_follow_in;
      cnt_ff        <= cnt_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_follow_ff <= rsp_follow_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_done_ff   <= rsp_done_in;
      if (reset) begin
         state_ff     <= IDLE;
         hf_ff        <= '0;
         la_fill_ff   <= '0;
         end_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hf_ff        <= hf_in;
         la_fill_ff   <= la_fill_in;
         end_ff       <= end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

/* sim/lz77e_checker.sv */
module lz77e_checker
   import lz77e_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   lz77e_req_if  req_mon,
   lz77e_rsp_if  rsp_mon,
   output int    err_count,
   output int    due_count
);

   localparam int WIN = WINDOW_DEFAULT;

   typedef struct packed {
      logic [FIELD_W-1:0]  back_offset;
      logic [FIELD_W-1:0]  match_length;
      logic [SYMBOL_W-1:0] follow_byte;
      logic                run_last;
      logic                stream_done;
   } lz_token_type;

   logic [SYMBOL_W-1:0] hist [WIN];
   logic [SYMBOL_W-1:0] ahead [WIN+1];
   int                  hist_n;
   int                  ahead_n;
   lz_token_type        tokens_due [$];

   task automatic push_hist(input logic [SYMBOL_W-1:0] b);
      if (hist_n < WIN) begin
         hist[hist_n] = b;
         hist_n++;
      end else begin
         for (int i = 0; i < WIN - 1; i++) hist[i] = hist[i+1];
         hist[WIN-1] = b;
      end
   endtask

   task automatic encode_symbol(input logic [SYMBOL_W-1:0] sym, input bit last);
      lz_token_type        made [WIN+1];
      int                  made_n;
      int                  span, best_len, best_pos, take, off;
      bit                  found, same;
      logic [SYMBOL_W-1:0] follow;
      made_n = 0;
      if (ahead_n < WIN + 1) begin
         ahead[ahead_n] = sym;
         ahead_n++;
      end
      while (ahead_n > 0 && (last || ahead_n >= hist_n + 1)) begin
         span = (hist_n < ahead_n) ? hist_n : ahead_n;
         found = 0;
         best_len = 0;
         best_pos = 0;
         for (int len = span; len >= 1 && !found; len--) begin
            for (int p = 0; p + len <= hist_n && !found; p++) begin
               same = 1;
               for (int k = 0; k < len; k++)
                  if (hist[p+k] != ahead[k]) same = 0;
               if (same) begin
                  found = 1;
                  best_len = len;
                  best_pos = p;
               end
            end
         end
         if (found) begin
            off = hist_n - best_pos;
            if (best_len < ahead_n) begin
               follow = ahead[best_len];
               take = best_len + 1;
            end else begin
               // match runs into the end of the stream
               follow = '0;
               take = best_len;
            end
         end else begin
            off = 0;
            best_len = 0;
            follow = ahead[0];
            take = 1;
         end
         made[made_n].back_offset  = off[FIELD_W-1:0];
         made[made_n].match_length = best_len[FIELD_W-1:0];
         made[made_n].follow_byte  = follow;
         made[made_n].run_last     = 1'b0;
         made[made_n].stream_done  = 1'b0;
         made_n++;
         for (int k = 0; k < take; k++) push_hist(ahead[k]);
         for (int k = 0; k + take < ahead_n; k++) ahead[k] = ahead[k+take];
         ahead_n -= take;
      end
      if (made_n > 0) begin
         made[made_n-1].run_last    = 1'b1;
         made[made_n-1].stream_done = last;
      end
      for (int i = 0; i < made_n; i++) tokens_due = {tokens_due, made[i]};
      if (last) begin
         hist_n = 0;
         ahead_n = 0;
      end
   endtask

   task automatic check_token();
      lz_token_type want;
      if (tokens_due.size() == 0) begin
         $error("token with none pending: off %0d len %0d byte %0h",
                rsp_mon.back_offset, rsp_mon.match_length, rsp_mon.follow_byte);
         err_count++;
      end else begin
         want = tokens_due.pop_front();
         if (rsp_mon.back_offset !== want.back_offset) begin
            $error("back_offset expected %0d got %0d", want.back_offset,
                   rsp_mon.back_offset);
            err_count++;
         end
         if (rsp_mon.match_length !== want.match_length) begin
            $error("match_length expected %0d got %0d", want.match_length,
                   rsp_mon.match_length);
            err_count++;
         end
         if (rsp_mon.follow_byte !== want.follow_byte) begin
            $error("follow_byte expected %0h got %0h", want.follow_byte,
                   rsp_mon.follow_byte);
            err_count++;
         end
         if (rsp_mon.run_last !== want.run_last) begin
            $error("run_last expected %0d got %0d", want.run_last, rsp_mon.run_last);
            err_count++;
         end
         if (rsp_mon.stream_done !== want.stream_done) begin
            $error("stream_done expected %0d got %0d", want.stream_done,
                   rsp_mon.stream_done);
            err_count++;
         end
      end
   endtask

   initial begin
      err_count = 0;
      due_count = 0;
      hist_n = 0;
      ahead_n = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         hist_n = 0;
         ahead_n = 0;
         tokens_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            encode_symbol(req_mon.symbol, req_mon.stream_end);
         if (rsp_mon.valid && rsp_mon.ready)
            check_token();
      end
      due_count = tokens_due.size();
   end

endmodule

/* sim/tb_top.sv */
module tb_top;
   import lz77e_pkg::*;

   logic clock;
   logic reset;
   int   err_count;
   int   due_count;
   int   n_sent;
   int   hold_left;
   bit   hold_go;
   bit   hold_done;
   bit   steady;

   logic [SYMBOL_W-1:0] palette [3];
   logic [SYMBOL_W:0]   directed [25];

   lz77e_req_if req_ch ();
   lz77e_rsp_if rsp_ch ();

   lz77_sliding_window_encoder_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   lz77e_checker check (
      .clock     (clock),
      .reset     (reset),
      .req_mon   (req_ch),
      .rsp_mon   (rsp_ch),
      .err_count (err_count),
      .due_count (due_count)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_symbol(input logic [SYMBOL_W-1:0] sym, input bit last);
      while (!steady && $urandom_range(99) < 13) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.symbol     <= sym;
      req_ch.stream_end <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      n_sent++;
      @(negedge clock);
   endtask

   // receiver: random stalls, one long hold-off to back the block up, no stalls while steady
   initial begin
      rsp_ch.ready = 1'b0;
      hold_left = 0;
      hold_done = 0;
      forever begin
         @(negedge clock);
         if (hold_go && !hold_done) begin
            hold_left = 400;
            hold_done = 1;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (steady) begin
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= 13);
         end
      end
   end

   initial begin
      int  len;
      int  pick;
      bit  wide;
      logic [SYMBOL_W-1:0] sym;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.symbol = '0;
      req_ch.stream_end = 1'b0;
      steady = 0;
      hold_go = 0;
      n_sent = 0;
      // {stream_end, symbol}
      directed = '{9'h100, 9'h1ff, 9'h061, 9'h161,
                   9'h001, 9'h002, 9'h001, 9'h002, 9'h104,
                   9'h080, 9'h040, 9'h020, 9'h010, 9'h008, 9'h004, 9'h002, 9'h001,
                   9'h080, 9'h040, 9'h020, 9'h010, 9'h008, 9'h004, 9'h002, 9'h101};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (directed[i]) send_symbol(directed[i][SYMBOL_W-1:0], directed[i][SYMBOL_W]);
      while (n_sent < 250) begin
         pick = $urandom_range(99);
         if (pick < 10) len = 1;
         else if (pick < 75) len = $urandom_range(16, 2);
         else if (pick < 95) len = $urandom_range(30, 17);
         else len = $urandom_range(60, 31);
         wide = ($urandom_range(99) < 35);
         foreach (palette[i]) palette[i] = $urandom_range(255);
         for (int i = 0; i < len; i++) begin
            if (wide) sym = $urandom_range(255);
            else sym = palette[$urandom_range(2)];
            if (n_sent >= 85) hold_go = 1;
            steady = (n_sent >= 150 && n_sent < 215);
            send_symbol(sym, i == len - 1);
         end
      end
      steady = 0;
      req_ch.valid <= 1'b0;
      while (due_count != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      if (err_count == 0 && due_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
